@@ rtl/prcd_pkg.sv @@
// Package for the pattern row code decoder: constants, controller states,
// command and status structs, and the per-track code extraction function.
// No dependencies; every other file of the block but prcd_checker imports it.
package prcd_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned ROWS_PER_PATTERN_DEF = 64;
    localparam int unsigned MAX_TRACKS_DEF       = 8;

    // Code word layout and cell size
    localparam int unsigned CODE_TOP_SHIFT = 14;
    localparam int unsigned FULL_CELL      = 7;

    // Track count register
    localparam int unsigned CFG_W         = 4;
    localparam logic [CFG_W-1:0] TRACKS_RESET = 4'd8;

    // Per-track codes
    localparam logic [1:0] CODE_EMPTY  = 2'd0;
    localparam logic [1:0] CODE_EFFECT = 2'd1;
    localparam logic [1:0] CODE_NOTE   = 2'd2;
    localparam logic [1:0] CODE_FULL   = 2'd3;

    // Cell byte positions
    localparam logic [2:0] POS_NOTE       = 3'd0;
    localparam logic [2:0] POS_INSTRUMENT = 3'd4;
    localparam logic [2:0] POS_EFFECT     = 3'd5;
    localparam logic [2:0] POS_NONE       = 3'd7;

    // Controller states: the first four take bytes, the rest work on one
    typedef enum logic [2:0] {
        ST_LOW,
        ST_HIGH,
        ST_PAYLOAD,
        ST_IDLE,
        ST_SCAN,
        ST_CELL,
        ST_TRUNC
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic restart;
        logic load_low;
        logic load_high;
        logic store_byte;
        logic open_payload;
        logic emit_cell;
        logic emit_empty;
        logic emit_trunc;
        logic row_inc;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic track_lt_limit;
        logic code_nonzero;
        logic payload_last;
        logic last_row;
        logic out_free;
    } sts_t;

    // Pick the 2-bit code of a track, track 0 in the top bits
    function automatic logic [1:0] code_of(input logic [15:0] word, input logic [2:0] trk);
        logic [15:0] sh;
        sh = word >> (5'(CODE_TOP_SHIFT) - {1'b0, trk, 1'b0});
        return sh[1:0];
    endfunction

endpackage

@@ rtl/pattern_row_code_decoder_core.sv @@
// Top level of the pattern row code decoder: controller plus datapath.
// Depends on prcd_pkg, prcd_ctrl and prcd_datapath.
//
//   channel | direction | handshake          | beat carries
//   --------+-----------+--------------------+-----------------------------------
//   in      | into      | in_valid/in_stall  | data_byte, pattern_start, final_byte
//   out     | out of    | out_valid/out_stall| row, track, 7 cell bytes, done, truncated
//   cfg     | into      | cfg_valid/cfg_ready| cfg_data = tracks_in_use
//
// A code word byte or a payload byte that does not finish a track is taken
// without a stall. A byte that finishes a track stalls the input while that cell
// is registered; then, as after the code word, the scan moves over the empty
// tracks (one empty cell per cycle through the single output register, while
// out_stall is low), stops at a track that opens a payload or at the row end,
// and ends with a truncation beat where one is due.
// Reset clears the phase to the code word low byte and sets tracks_in_use 8.
// out_stall freezes the output register and the scan of empty tracks; cfg_ready is always high.
module pattern_row_code_decoder_core #(
    parameter int unsigned ROWS_PER_PATTERN = prcd_pkg::ROWS_PER_PATTERN_DEF,
    parameter int unsigned MAX_TRACKS       = prcd_pkg::MAX_TRACKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        pattern_start,
    input  logic                        final_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [5:0]                  row_index,
    output logic [2:0]                  track_index,
    output logic [7:0]                  note_byte,
    output logic [7:0]                  chord_one,
    output logic [7:0]                  chord_two,
    output logic [7:0]                  chord_three,
    output logic [7:0]                  instrument_byte,
    output logic [7:0]                  effect_byte,
    output logic [7:0]                  effect_param,
    output logic                        pattern_done,
    output logic                        truncated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [prcd_pkg::CFG_W-1:0]  cfg_data
);
    import prcd_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    // Register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    prcd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pattern_start (pattern_start),
        .final_byte    (final_byte),
        .sts           (sts),
        .cmd           (cmd)
    );

    prcd_datapath #(
        .ROWS_PER_PATTERN (ROWS_PER_PATTERN),
        .MAX_TRACKS       (MAX_TRACKS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .data_byte       (data_byte),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .row_index       (row_index),
        .track_index     (track_index),
        .note_byte       (note_byte),
        .chord_one       (chord_one),
        .chord_two       (chord_two),
        .chord_three     (chord_three),
        .instrument_byte (instrument_byte),
        .effect_byte     (effect_byte),
        .effect_param    (effect_param),
        .pattern_done    (pattern_done),
        .truncated       (truncated)
    );

endmodule

@@ rtl/prcd_ctrl.sv @@
// Controller of the pattern row code decoder: phase state machine, input
// stall, and the command struct to the datapath. Depends on prcd_pkg.
module prcd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            pattern_start,
    input  logic            final_byte,
    input  prcd_pkg::sts_t  sts,
    output prcd_pkg::cmd_t  cmd
);
    import prcd_pkg::*;

    state_t state_reg, state_next;
    logic   final_reg, final_next;
    state_t phase;
    logic   accept;

    // Take bytes only in the decode phases
    assign in_stall = !((state_reg == ST_LOW) || (state_reg == ST_HIGH) ||
                        (state_reg == ST_PAYLOAD) || (state_reg == ST_IDLE));
    assign accept   = in_valid && !in_stall;

    // Pattern start forces the code word low byte
    always_comb
    begin
        phase = pattern_start ? ST_LOW : state_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        unique case (state_reg)
            ST_LOW, ST_HIGH, ST_PAYLOAD, ST_IDLE:
            begin
                if (accept)
                begin
                    final_next = final_byte;
                    unique case (phase)
                        ST_LOW:     state_next = final_byte ? ST_TRUNC : ST_HIGH;
                        ST_HIGH:    state_next = ST_SCAN;
                        ST_PAYLOAD:
                        begin
                            if (sts.payload_last)
                                state_next = ST_CELL;
                            else
                                state_next = final_byte ? ST_TRUNC : ST_PAYLOAD;
                        end
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CELL:
            begin
                if (sts.out_free)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.track_lt_limit)
                begin
                    if (sts.code_nonzero)
                        state_next = final_reg ? ST_TRUNC : ST_PAYLOAD;
                end
                else if (sts.last_row)
                    state_next = ST_IDLE;
                else
                    state_next = final_reg ? ST_TRUNC : ST_LOW;
            end
            ST_TRUNC:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd              = '0;
        cmd.restart      = accept && pattern_start;
        cmd.load_low     = accept && (phase == ST_LOW);
        cmd.load_high    = accept && (phase == ST_HIGH);
        cmd.store_byte   = accept && (phase == ST_PAYLOAD);
        unique case (state_reg)
            ST_SCAN:
            begin
                cmd.open_payload = sts.track_lt_limit && sts.code_nonzero;
                cmd.emit_empty   = sts.track_lt_limit && !sts.code_nonzero && sts.out_free;
                cmd.row_inc      = !sts.track_lt_limit && !sts.last_row;
            end
            ST_CELL:  cmd.emit_cell  = sts.out_free;
            ST_TRUNC: cmd.emit_trunc = sts.out_free;
            default:  cmd.row_inc    = 1'b0;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOW;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

endmodule

@@ rtl/prcd_datapath.sv @@
// Datapath of the pattern row code decoder: code word, row and track
// counters, cell byte store, track count register and output register.
// Depends on prcd_pkg.
module prcd_datapath #(
    parameter int unsigned ROWS_PER_PATTERN = prcd_pkg::ROWS_PER_PATTERN_DEF,
    parameter int unsigned MAX_TRACKS       = prcd_pkg::MAX_TRACKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  prcd_pkg::cmd_t              cmd,
    output prcd_pkg::sts_t              sts,
    input  logic                        cfg_we,
    input  logic [prcd_pkg::CFG_W-1:0]  cfg_data,
    input  logic [7:0]                  data_byte,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [5:0]                  row_index,
    output logic [2:0]                  track_index,
    output logic [7:0]                  note_byte,
    output logic [7:0]                  chord_one,
    output logic [7:0]                  chord_two,
    output logic [7:0]                  chord_three,
    output logic [7:0]                  instrument_byte,
    output logic [7:0]                  effect_byte,
    output logic [7:0]                  effect_param,
    output logic                        pattern_done,
    output logic                        truncated
);
    import prcd_pkg::*;

    localparam int unsigned ROW_W = (ROWS_PER_PATTERN > 1) ? $clog2(ROWS_PER_PATTERN) : 1;
    localparam int unsigned TRK_W = $clog2(MAX_TRACKS + 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_PATTERN - 1);
    localparam logic [CFG_W-1:0] TRK_MAX  = CFG_W'(MAX_TRACKS);

    logic [CFG_W-1:0] tracks_reg;
    logic [15:0]      code_word_reg;
    logic [TRK_W-1:0] track_reg;
    logic [ROW_W-1:0] row_reg;
    logic [2:0]       count_reg;
    logic [7:0]       cell_reg [FULL_CELL];
    logic             out_valid_reg;

    logic [5:0]       row_index_reg;
    logic [2:0]       track_index_reg;
    logic [7:0]       out_bytes_reg [FULL_CELL];
    logic             done_reg;
    logic             trunc_reg;

    logic [CFG_W-1:0] trk_limit;
    logic [CFG_W-1:0] track_ext;
    logic [2:0]       trk3;
    logic [1:0]       cur_code;
    logic [2:0]       need;
    logic [2:0]       pos;
    logic             last_cell;
    logic             emit_any;

    // Clamp the track count and pick the current track's code
    always_comb
    begin
        trk_limit = ((tracks_reg == '0) || (tracks_reg > TRK_MAX)) ? TRK_MAX : tracks_reg;
        track_ext = CFG_W'(track_reg);
        trk3      = 3'(track_reg);
        cur_code  = code_of(code_word_reg, trk3);
        need      = (cur_code == CODE_FULL) ? 3'(FULL_CELL) : 3'd2;
    end

    // Where the next payload byte lands in the cell
    always_comb
    begin
        case (cur_code)
            CODE_EFFECT: pos = POS_EFFECT + {2'b00, count_reg[0]};
            CODE_NOTE:   pos = (count_reg == 3'd0) ? POS_NOTE : POS_INSTRUMENT;
            default:     pos = count_reg;
        endcase
    end

    // Status to the controller
    always_comb
    begin
        last_cell          = (({1'b0, track_ext} + 5'd1) >= {1'b0, trk_limit}) &&
                             (row_reg == LAST_ROW);
        sts.track_lt_limit = track_ext < trk_limit;
        sts.code_nonzero   = cur_code != CODE_EMPTY;
        sts.payload_last   = ({1'b0, count_reg} + 4'd1) >= {1'b0, need};
        sts.last_row       = row_reg == LAST_ROW;
        sts.out_free       = !out_valid_reg || !out_stall;
    end

    assign emit_any = cmd.emit_cell || cmd.emit_empty || cmd.emit_trunc;

    // Counters, track count register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracks_reg    <= TRACKS_RESET;
            track_reg     <= '0;
            row_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tracks_reg <= cfg_data;
            if (cmd.restart)
            begin
                row_reg   <= '0;
                track_reg <= '0;
                count_reg <= '0;
            end
            if (cmd.load_high)
                track_reg <= '0;
            if (cmd.store_byte)
                count_reg <= sts.payload_last ? 3'd0 : count_reg + 3'd1;
            if (cmd.open_payload)
                count_reg <= '0;
            if (cmd.emit_cell || cmd.emit_empty)
                track_reg <= track_reg + TRK_W'(1);
            if (cmd.row_inc)
            begin
                row_reg   <= row_reg + ROW_W'(1);
                track_reg <= '0;
            end
            if (emit_any)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Code word, cell store and output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_low)
            code_word_reg[7:0] <= data_byte;
        if (cmd.load_high)
            code_word_reg[15:8] <= data_byte;
        if (cmd.open_payload)
        begin
            for (int i = 0; i < FULL_CELL; i++)
                cell_reg[i] <= '0;
        end
        if (cmd.store_byte && (pos != POS_NONE))
            cell_reg[pos] <= data_byte;
        if (emit_any)
        begin
            row_index_reg   <= cmd.emit_trunc ? 6'd0 : 6'(row_reg);
            track_index_reg <= cmd.emit_trunc ? 3'd0 : trk3;
            done_reg        <= !cmd.emit_trunc && last_cell;
            trunc_reg       <= cmd.emit_trunc;
            for (int i = 0; i < FULL_CELL; i++)
                out_bytes_reg[i] <= cmd.emit_cell ? cell_reg[i] : 8'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign row_index       = row_index_reg;
    assign track_index     = track_index_reg;
    assign note_byte       = out_bytes_reg[0];
    assign chord_one       = out_bytes_reg[1];
    assign chord_two       = out_bytes_reg[2];
    assign chord_three     = out_bytes_reg[3];
    assign instrument_byte = out_bytes_reg[4];
    assign effect_byte     = out_bytes_reg[5];
    assign effect_param    = out_bytes_reg[6];
    assign pattern_done    = done_reg;
    assign truncated       = trunc_reg;

endmodule

@@ rtl/prcd_checker.sv @@
// Port-level checker for the pattern row code decoder, bound to the top level.
// Depends on pattern_row_code_decoder_core only through its ports.
module prcd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [5:0] row_index,
    input logic [2:0] track_index,
    input logic [7:0] note_byte,
    input logic [7:0] chord_one,
    input logic [7:0] chord_two,
    input logic [7:0] chord_three,
    input logic [7:0] instrument_byte,
    input logic [7:0] effect_byte,
    input logic [7:0] effect_param,
    input logic       pattern_done,
    input logic       truncated
);

    // A truncation beat carries nothing else
    a_trunc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |->
            row_index == 6'd0 && track_index == 3'd0 && note_byte == 8'd0 &&
            chord_one == 8'd0 && chord_two == 8'd0 && chord_three == 8'd0 &&
            instrument_byte == 8'd0 && effect_byte == 8'd0 &&
            effect_param == 8'd0 && !pattern_done)
        else $error("truncation beat with non-zero fields");

    // A completed pattern never also reports truncation
    a_done_not_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pattern_done |-> !truncated)
        else $error("pattern done and truncated together");

    // Hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_index) &&
            $stable(track_index) && $stable(note_byte) && $stable(effect_param) &&
            $stable(pattern_done) && $stable(truncated))
        else $error("stalled output beat changed");

endmodule

bind pattern_row_code_decoder_core prcd_checker u_prcd_checker (.*);
